### hw/rtl/bclm_pkg.sv
// Shared types and codes for the block cache LRU manager.
// Holds the request and result structs and the controller-to-datapath command and status.
// Depends on nothing.
package bclm_pkg;

	localparam int CHANNEL_BITS = 8;
	localparam int BLOCK_BITS   = 32;
	localparam int KIND_BITS    = 3;
	localparam int SLOT_BITS    = 4;
	localparam int STATUS_BITS  = 3;

	// Request kinds.
	localparam logic [KIND_BITS-1:0] K_CREATE     = 3'd0;
	localparam logic [KIND_BITS-1:0] K_GET        = 3'd1;
	localparam logic [KIND_BITS-1:0] K_MODIFY     = 3'd2;
	localparam logic [KIND_BITS-1:0] K_RELEASE    = 3'd3;
	localparam logic [KIND_BITS-1:0] K_INVALIDATE = 3'd4;
	localparam logic [KIND_BITS-1:0] K_SYNC       = 3'd5;

	// Result status codes.
	localparam logic [STATUS_BITS-1:0] ST_OK       = 3'd0;
	localparam logic [STATUS_BITS-1:0] ST_FALSE    = 3'd1;
	localparam logic [STATUS_BITS-1:0] ST_WB_REQ   = 3'd2;
	localparam logic [STATUS_BITS-1:0] ST_RD_REQ   = 3'd3;
	localparam logic [STATUS_BITS-1:0] ST_NO_SLOT  = 3'd4;
	localparam logic [STATUS_BITS-1:0] ST_WR_ERR   = 3'd5;
	localparam logic [STATUS_BITS-1:0] ST_RD_ERR   = 3'd6;

	// List membership codes.
	localparam logic [1:0] L_FREE   = 2'd0;
	localparam logic [1:0] L_LRU    = 2'd1;
	localparam logic [1:0] L_PINNED = 2'd2;

	typedef struct packed {
		logic [KIND_BITS-1:0]    kind;
		logic [CHANNEL_BITS-1:0] channel;
		logic [BLOCK_BITS-1:0]   block_number;
		logic [SLOT_BITS-1:0]    slot;
		logic                    handle_valid;
		logic                    mark_dirty;
		logic                    unmount;
		logic                    write_ok;
		logic                    read_ok;
	} req_t;

	typedef struct packed {
		logic [STATUS_BITS-1:0]  status;
		logic [SLOT_BITS-1:0]    result_slot;
		logic [CHANNEL_BITS-1:0] result_channel;
		logic [BLOCK_BITS-1:0]   result_block;
		logic                    last;
	} rsp_t;

	typedef enum logic [1:0] {PICK_NONE, PICK_ACQ, PICK_POS} pick_t;

	typedef enum logic [2:0] {
		ACT_NONE, ACT_RETAG, ACT_GRANT, ACT_FILL_FAIL, ACT_DISPOSE,
		ACT_HANDLE, ACT_SYNC, ACT_SKIP
	} act_t;

	typedef enum logic [2:0] {SRC_ZERO, SRC_SEL_KEY, SRC_SEL_TAG, SRC_ECHO, SRC_ZERO_KEY,
		SRC_CHAN} src_t;

	typedef struct packed {
		logic                   load;
		logic                   clear;
		logic                   scan;
		pick_t                  pick;
		act_t                   act;
		logic                   emit;
		logic [STATUS_BITS-1:0] st;
		src_t                   src;
		logic                   last;
	} cmd_t;

	typedef struct packed {
		logic [KIND_BITS-1:0] kind;
		logic                 hit;
		logic                 fhead_ok;
		logic                 lhead_ok;
		logic                 sel_dirty;
		logic                 sel_chan_eq;
		logic                 scan_last;
		logic                 handle_bad;
		logic                 rem_zero;
		logic                 write_ok;
		logic                 read_ok;
	} stat_t;

endpackage

### hw/rtl/bclm_datapath.sv
// Slot metadata store, scan unit, list ordering and result register of the cache manager.
// Depends on bclm_pkg; driven by bclm_ctrl through cmd_t and reports through stat_t.
module bclm_datapath #(
	parameter int NUM_SLOTS = 16,
	parameter int PIN_BITS  = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  bclm_pkg::cmd_t cmd,
	input  bclm_pkg::req_t request,
	output bclm_pkg::stat_t stat,
	output logic          result_strobe,
	output bclm_pkg::rsp_t result
);
	import bclm_pkg::*;

	localparam int IW = $clog2(NUM_SLOTS);
	localparam int CW = $clog2(NUM_SLOTS + 1);
	localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};

	req_t req_q;
	logic [CHANNEL_BITS-1:0] tag_ch_q [NUM_SLOTS];
	logic [BLOCK_BITS-1:0]   tag_bl_q [NUM_SLOTS];
	logic [NUM_SLOTS-1:0]    valid_q, dirty_q;
	logic [PIN_BITS-1:0]     pin_q [NUM_SLOTS];
	logic [1:0]              member_q [NUM_SLOTS];
	logic [IW-1:0]           rank_q [NUM_SLOTS];
	logic [CW-1:0]           cnt_free_q, cnt_lru_q, cnt_pin_q;

	logic [IW-1:0] idx_q, sel_q, hit_slot_q, fh_slot_q, lh_slot_q, pm_slot_q, pos_q;
	logic          hit_q, fh_q, lh_q;
	logic [CW-1:0] rem_q;
	logic          strobe_q;
	rsp_t          rsp_q;

	// Scan probes at the current index.
	logic s_hit, s_fh, s_lh, s_pm, scan_last;
	assign s_hit = valid_q[idx_q] && tag_ch_q[idx_q] == req_q.channel
		&& tag_bl_q[idx_q] == req_q.block_number;
	assign s_fh = member_q[idx_q] == L_FREE && rank_q[idx_q] == '0;
	assign s_lh = member_q[idx_q] == L_LRU && rank_q[idx_q] == '0;
	assign s_pm = member_q[idx_q] == L_LRU && rank_q[idx_q] == pos_q;
	assign scan_last = idx_q == IW'(NUM_SLOTS - 1);

	logic          handle_bad;
	logic [IW-1:0] hs;
	assign handle_bad = !req_q.handle_valid || int'(req_q.slot) >= NUM_SLOTS;
	assign hs = IW'(32'(req_q.slot));

	// List move request.
	logic          mv_en, mv_head;
	logic [IW-1:0] mv_slot;
	logic [1:0]    mv_list;

	always_comb begin
		mv_en = 1'b0;
		mv_head = 1'b1;
		mv_slot = sel_q;
		mv_list = L_FREE;
		case (cmd.act)
			ACT_GRANT: begin
				mv_en = 1'b1;
				mv_list = L_PINNED;
			end
			ACT_FILL_FAIL, ACT_DISPOSE: mv_en = 1'b1;
			ACT_SYNC: mv_en = req_q.unmount;
			ACT_HANDLE: begin
				mv_slot = hs;
				mv_list = L_LRU;
				mv_head = 1'b0;
				mv_en = req_q.kind == K_RELEASE && pin_q[hs] == PIN_BITS'(1);
			end
			default: mv_en = 1'b0;
		endcase
	end

	logic [1:0]    old_m;
	logic [IW-1:0] old_r, tail_r;
	logic [CW-1:0] cnt_l;
	logic [1:0]    mem_nx [NUM_SLOTS];
	logic [IW-1:0] rank_nx [NUM_SLOTS];
	logic [CW-1:0] cnt_free_nx, cnt_lru_nx, cnt_pin_nx;

	always_comb begin
		old_m = member_q[mv_slot];
		old_r = rank_q[mv_slot];
		case (mv_list)
			L_FREE:   cnt_l = cnt_free_q;
			L_LRU:    cnt_l = cnt_lru_q;
			default:  cnt_l = cnt_pin_q;
		endcase
		tail_r = IW'(cnt_l - ((old_m == mv_list) ? CW'(1) : CW'(0)));
		cnt_free_nx = cnt_free_q;
		cnt_lru_nx = cnt_lru_q;
		cnt_pin_nx = cnt_pin_q;
		for (int t = 0; t < NUM_SLOTS; t++) begin
			mem_nx[t] = member_q[t];
			rank_nx[t] = rank_q[t];
			if (mv_en) begin
				if (IW'(t) == mv_slot) begin
					mem_nx[t] = mv_list;
					rank_nx[t] = mv_head ? '0 : tail_r;
				end else begin
					if (member_q[t] == old_m && rank_q[t] > old_r)
						rank_nx[t] = rank_nx[t] - IW'(1);
					if (mv_head && member_q[t] == mv_list)
						rank_nx[t] = rank_nx[t] + IW'(1);
				end
			end
		end
		if (mv_en) begin
			case (old_m)
				L_FREE:  cnt_free_nx = cnt_free_nx - CW'(1);
				L_LRU:   cnt_lru_nx = cnt_lru_nx - CW'(1);
				default: cnt_pin_nx = cnt_pin_nx - CW'(1);
			endcase
			case (mv_list)
				L_FREE:  cnt_free_nx = cnt_free_nx + CW'(1);
				L_LRU:   cnt_lru_nx = cnt_lru_nx + CW'(1);
				default: cnt_pin_nx = cnt_pin_nx + CW'(1);
			endcase
		end
	end

	// Slot control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			dirty_q <= '0;
			for (int t = 0; t < NUM_SLOTS; t++) begin
				pin_q[t] <= '0;
				member_q[t] <= L_FREE;
				rank_q[t] <= IW'(t);
			end
			cnt_free_q <= CW'(NUM_SLOTS);
			cnt_lru_q <= '0;
			cnt_pin_q <= '0;
		end else begin
			for (int t = 0; t < NUM_SLOTS; t++) begin
				member_q[t] <= mem_nx[t];
				rank_q[t] <= rank_nx[t];
			end
			cnt_free_q <= cnt_free_nx;
			cnt_lru_q <= cnt_lru_nx;
			cnt_pin_q <= cnt_pin_nx;
			case (cmd.act)
				ACT_RETAG: begin
					valid_q[sel_q] <= 1'b0;
					dirty_q[sel_q] <= 1'b0;
					pin_q[sel_q] <= '0;
				end
				ACT_GRANT: begin
					valid_q[sel_q] <= 1'b1;
					if (pin_q[sel_q] != PIN_MAX)
						pin_q[sel_q] <= pin_q[sel_q] + PIN_BITS'(1);
				end
				ACT_DISPOSE: valid_q[sel_q] <= 1'b0;
				ACT_SYNC: begin
					dirty_q[sel_q] <= 1'b0;
					if (req_q.unmount)
						valid_q[sel_q] <= 1'b0;
				end
				ACT_HANDLE: begin
					if (req_q.kind == K_MODIFY || req_q.mark_dirty)
						dirty_q[hs] <= 1'b1;
					if (req_q.kind == K_RELEASE && pin_q[hs] != '0)
						pin_q[hs] <= pin_q[hs] - PIN_BITS'(1);
				end
				default: ;
			endcase
		end
	end

	// Tags carry no reset; they are written before any valid read.
	always_ff @(posedge clk) begin
		if (cmd.act == ACT_RETAG) begin
			tag_ch_q[sel_q] <= req_q.channel;
			tag_bl_q[sel_q] <= req_q.block_number;
		end
	end

	// Request register, scan and sweep bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			hit_q <= 1'b0;
			fh_q <= 1'b0;
			lh_q <= 1'b0;
			hit_slot_q <= '0;
			fh_slot_q <= '0;
			lh_slot_q <= '0;
			pm_slot_q <= '0;
			pos_q <= '0;
			rem_q <= '0;
		end else begin
			if (cmd.load || cmd.clear) begin
				idx_q <= '0;
				hit_q <= 1'b0;
				fh_q <= 1'b0;
				lh_q <= 1'b0;
			end else if (cmd.scan) begin
				idx_q <= idx_q + IW'(1);
				if (s_hit && !hit_q) begin
					hit_q <= 1'b1;
					hit_slot_q <= idx_q;
				end
				if (s_fh) begin
					fh_q <= 1'b1;
					fh_slot_q <= idx_q;
				end
				if (s_lh) begin
					lh_q <= 1'b1;
					lh_slot_q <= idx_q;
				end
				if (s_pm)
					pm_slot_q <= idx_q;
			end
			if (cmd.load) begin
				pos_q <= '0;
				rem_q <= cnt_lru_q;
			end else if (cmd.act == ACT_SKIP || (cmd.act == ACT_SYNC && !req_q.unmount)) begin
				pos_q <= pos_q + IW'(1);
				rem_q <= rem_q - CW'(1);
			end else if (cmd.act == ACT_SYNC) begin
				rem_q <= rem_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			req_q <= request;
		case (cmd.pick)
			PICK_ACQ: sel_q <= hit_q ? hit_slot_q : (fh_q ? fh_slot_q : lh_slot_q);
			PICK_POS: sel_q <= pm_slot_q;
			default: ;
		endcase
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			strobe_q <= 1'b0;
		else
			strobe_q <= cmd.emit;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rsp_q.status <= cmd.st;
			rsp_q.last <= cmd.last;
			rsp_q.result_slot <= '0;
			rsp_q.result_channel <= '0;
			rsp_q.result_block <= '0;
			case (cmd.src)
				SRC_SEL_KEY: begin
					rsp_q.result_slot <= SLOT_BITS'(sel_q);
					rsp_q.result_channel <= req_q.channel;
					rsp_q.result_block <= req_q.block_number;
				end
				SRC_SEL_TAG: begin
					rsp_q.result_slot <= SLOT_BITS'(sel_q);
					rsp_q.result_channel <= tag_ch_q[sel_q];
					rsp_q.result_block <= tag_bl_q[sel_q];
				end
				SRC_ECHO: rsp_q.result_slot <= req_q.slot;
				SRC_ZERO_KEY: begin
					rsp_q.result_channel <= req_q.channel;
					rsp_q.result_block <= req_q.block_number;
				end
				SRC_CHAN: rsp_q.result_channel <= req_q.channel;
				default: ;
			endcase
		end
	end

	assign result_strobe = strobe_q;
	assign result = rsp_q;

	assign stat.kind = req_q.kind;
	assign stat.hit = hit_q;
	assign stat.fhead_ok = fh_q;
	assign stat.lhead_ok = lh_q;
	assign stat.sel_dirty = dirty_q[sel_q];
	assign stat.sel_chan_eq = tag_ch_q[sel_q] == req_q.channel;
	assign stat.scan_last = scan_last;
	assign stat.handle_bad = handle_bad;
	assign stat.rem_zero = rem_q == '0;
	assign stat.write_ok = req_q.write_ok;
	assign stat.read_ok = req_q.read_ok;

endmodule

### hw/rtl/bclm_ctrl.sv
// Sequencing state machine of the cache manager.
// Depends on bclm_pkg; issues cmd_t to bclm_datapath and reads its stat_t.
module bclm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  bclm_pkg::stat_t stat,
	output bclm_pkg::cmd_t  cmd,
	output logic           busy
);
	import bclm_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_DISPATCH, S_SCAN, S_PICK, S_DECIDE, S_WERR, S_RETAG, S_FINISH,
		S_HANDLE, S_SYNC_CHK, S_SSCAN, S_SPICK, S_SVISIT
	} state_t;

	state_t state_q, state_nx;
	logic   busy_q;

	always_comb begin
		cmd = '0;
		cmd.pick = PICK_NONE;
		cmd.act = ACT_NONE;
		cmd.src = SRC_ZERO;
		cmd.st = ST_OK;
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				cmd.load = start;
				if (start)
					state_nx = S_DISPATCH;
			end
			S_DISPATCH: begin
				case (stat.kind)
					K_CREATE, K_GET, K_INVALIDATE: state_nx = S_SCAN;
					K_MODIFY, K_RELEASE: state_nx = S_HANDLE;
					K_SYNC: state_nx = S_SYNC_CHK;
					default: begin
						cmd.emit = 1'b1;
						cmd.st = ST_FALSE;
						cmd.last = 1'b1;
						state_nx = S_IDLE;
					end
				endcase
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_last)
					state_nx = S_PICK;
			end
			S_PICK: begin
				cmd.pick = PICK_ACQ;
				state_nx = S_DECIDE;
			end
			S_DECIDE: begin
				if (stat.kind == K_INVALIDATE) begin
					cmd.emit = 1'b1;
					cmd.last = 1'b1;
					state_nx = S_IDLE;
					if (stat.hit) begin
						cmd.act = ACT_DISPOSE;
						cmd.src = SRC_SEL_KEY;
					end else begin
						cmd.st = ST_FALSE;
						cmd.src = SRC_ZERO_KEY;
					end
				end else if (stat.hit) begin
					cmd.act = ACT_GRANT;
					cmd.emit = 1'b1;
					cmd.src = SRC_SEL_KEY;
					cmd.last = 1'b1;
					state_nx = S_IDLE;
				end else if (stat.fhead_ok) begin
					state_nx = S_RETAG;
				end else if (stat.lhead_ok) begin
					state_nx = S_RETAG;
					if (stat.sel_dirty) begin
						cmd.emit = 1'b1;
						cmd.st = ST_WB_REQ;
						cmd.src = SRC_SEL_TAG;
						if (!stat.write_ok)
							state_nx = S_WERR;
					end
				end else begin
					cmd.emit = 1'b1;
					cmd.st = ST_NO_SLOT;
					cmd.src = SRC_ZERO_KEY;
					cmd.last = 1'b1;
					state_nx = S_IDLE;
				end
			end
			S_WERR: begin
				cmd.emit = 1'b1;
				cmd.st = ST_WR_ERR;
				cmd.src = SRC_SEL_TAG;
				cmd.last = 1'b1;
				state_nx = S_IDLE;
			end
			S_RETAG: begin
				cmd.act = ACT_RETAG;
				if (stat.kind == K_GET) begin
					cmd.emit = 1'b1;
					cmd.st = ST_RD_REQ;
					cmd.src = SRC_SEL_KEY;
				end
				state_nx = S_FINISH;
			end
			S_FINISH: begin
				cmd.emit = 1'b1;
				cmd.src = SRC_SEL_KEY;
				cmd.last = 1'b1;
				state_nx = S_IDLE;
				if (stat.kind == K_GET && !stat.read_ok) begin
					cmd.act = ACT_FILL_FAIL;
					cmd.st = ST_RD_ERR;
				end else begin
					cmd.act = ACT_GRANT;
				end
			end
			S_HANDLE: begin
				cmd.emit = 1'b1;
				cmd.src = SRC_ECHO;
				cmd.last = 1'b1;
				state_nx = S_IDLE;
				if (stat.handle_bad)
					cmd.st = ST_FALSE;
				else
					cmd.act = ACT_HANDLE;
			end
			S_SYNC_CHK: begin
				if (stat.rem_zero) begin
					cmd.emit = 1'b1;
					cmd.src = SRC_CHAN;
					cmd.last = 1'b1;
					state_nx = S_IDLE;
				end else begin
					cmd.clear = 1'b1;
					state_nx = S_SSCAN;
				end
			end
			S_SSCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_last)
					state_nx = S_SPICK;
			end
			S_SPICK: begin
				cmd.pick = PICK_POS;
				state_nx = S_SVISIT;
			end
			S_SVISIT: begin
				state_nx = S_SYNC_CHK;
				if (!stat.sel_chan_eq) begin
					cmd.act = ACT_SKIP;
				end else if (stat.sel_dirty) begin
					cmd.emit = 1'b1;
					cmd.st = ST_WB_REQ;
					cmd.src = SRC_SEL_TAG;
					if (!stat.write_ok)
						state_nx = S_WERR;
					else
						cmd.act = ACT_SYNC;
				end else begin
					cmd.act = ACT_SYNC;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			busy_q <= state_nx != S_IDLE;
		end
	end

	assign busy = busy_q;

endmodule

### hw/rtl/block_cache_lru_manager_core.sv
// Top level of the block cache LRU manager.
// Depends on bclm_pkg, bclm_ctrl and bclm_datapath.
//
// A request is taken when start is high and busy is low; busy then stays high and falls in
// the same cycle that the final result appears. Each result appears on result for one
// cycle with result_strobe high, and the receiver must take it then, since it cannot stall
// the block. The final result of a request has result.last set. Lookups walk the slots one
// per cycle through the datapath's scan port; modify and release do not scan, and
// synchronize repeats the scan once for every slot on the LRU list, because each step of
// the sweep scans for the slot at the next LRU position. No clearing pass is run after
// reset: the list order, pin counts and valid marks reset at once.
module block_cache_lru_manager_core #(
	parameter int NUM_SLOTS = 16,
	parameter int PIN_BITS  = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  bclm_pkg::req_t request,
	output logic           result_strobe,
	output bclm_pkg::rsp_t result
);
	import bclm_pkg::*;

	// The controller and datapath talk only through these two structs.
	cmd_t  cmd;
	stat_t stat;

	bclm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	bclm_datapath #(
		.NUM_SLOTS (NUM_SLOTS),
		.PIN_BITS  (PIN_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.request       (request),
		.stat          (stat),
		.result_strobe (result_strobe),
		.result        (result)
	);

endmodule
